[hdl/hlcd_pkg.sv]
// ----------------------------------------------------------------------------
// hlcd_pkg: shared types and constants
// Packet framing constants, status codes, register indexes and the structs
// passed between the deframer modules.
// ----------------------------------------------------------------------------
package hlcd_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned SizeW  = 9;
	localparam int unsigned StatW  = 3;
	localparam int unsigned IndexW = 8;

	localparam logic [ByteW-1:0] HdrByte     = 8'hFF;
	localparam logic [SizeW-1:0] LenOverhead = 9'd4;

	// Byte positions inside a packet
	localparam logic [SizeW-1:0] PosHdr1   = 9'd1;
	localparam logic [SizeW-1:0] PosHdr2   = 9'd2;
	localparam logic [SizeW-1:0] PosLength = 9'd3;
	localparam logic [SizeW-1:0] PosFirst  = 9'd4;

	// Status codes
	localparam logic [StatW-1:0] StIdle    = 3'd0;
	localparam logic [StatW-1:0] StHdrErr  = 3'd1;
	localparam logic [StatW-1:0] StLenErr  = 3'd2;
	localparam logic [StatW-1:0] StCsumErr = 3'd3;
	localparam logic [StatW-1:0] StDone    = 3'd4;

	// Register indexes
	localparam logic [IndexW-1:0] RegMinSize = 8'd0;
	localparam logic [IndexW-1:0] RegMaxSize = 8'd1;

	localparam logic [SizeW-1:0] MinSizeReset = 9'd6;
	localparam logic [SizeW-1:0] MaxSizeReset = 9'd259;

	typedef struct packed {
		logic [SizeW-1:0] min_size;
		logic [SizeW-1:0] max_size;
	} cfg_t;

	typedef struct packed {
		logic [StatW-1:0] status;
		logic [SizeW-1:0] packet_length;
		logic             byte_stored;
		logic [SizeW-1:0] byte_index;
		logic [ByteW-1:0] data_byte;
	} result_t;

endpackage

[hdl/hlcd_cfg.sv]
// ----------------------------------------------------------------------------
// hlcd_cfg: configuration registers
// Holds the min and max packet size limits, written through the config port.
// ----------------------------------------------------------------------------
module hlcd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [hlcd_pkg::IndexW-1:0]   cfg_index,
	input  logic [hlcd_pkg::SizeW-1:0]    cfg_data,
	output hlcd_pkg::cfg_t                cfg
);

	hlcd_pkg::cfg_t cfg_q;

	// Register writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_size <= hlcd_pkg::MinSizeReset;
			cfg_q.max_size <= hlcd_pkg::MaxSizeReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hlcd_pkg::RegMinSize: cfg_q.min_size <= cfg_data;
				hlcd_pkg::RegMaxSize: cfg_q.max_size <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/hlcd_parse.sv]
// ----------------------------------------------------------------------------
// hlcd_parse: packet parser
// Frame state (count, expected size, running sum) and the per-byte decision
// logic that produces one result word for each accepted byte.
// ----------------------------------------------------------------------------
module hlcd_parse (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [hlcd_pkg::ByteW-1:0]  rx_byte,
	input  hlcd_pkg::cfg_t              cfg,
	output hlcd_pkg::result_t           result
);

	logic [hlcd_pkg::SizeW-1:0] count_q;
	logic [hlcd_pkg::SizeW-1:0] exp_len_q;
	logic [hlcd_pkg::ByteW-1:0] sum_q;

	logic [hlcd_pkg::SizeW-1:0] count_d;
	logic [hlcd_pkg::SizeW-1:0] exp_len_d;
	logic [hlcd_pkg::ByteW-1:0] sum_d;
	logic [hlcd_pkg::SizeW:0]   cnt_next;
	logic [hlcd_pkg::ByteW-1:0] sum_add;
	logic                       len_bad;
	hlcd_pkg::result_t          res;

	assign cnt_next = {1'b0, count_q} + 10'd1;
	assign sum_add  = sum_q + rx_byte;
	assign len_bad  = (exp_len_q < cfg.min_size) || (exp_len_q > cfg.max_size);

	// Per-byte decision
	always_comb begin
		count_d           = count_q;
		exp_len_d         = exp_len_q;
		sum_d             = sum_q;
		res.status        = hlcd_pkg::StIdle;
		res.packet_length = '0;
		res.byte_stored   = 1'b0;
		res.byte_index    = '0;
		res.data_byte     = '0;
		if (count_q < hlcd_pkg::PosHdr2) begin
			// header bytes
			if (rx_byte != hlcd_pkg::HdrByte) begin
				count_d    = '0;
				sum_d      = '0;
				res.status = hlcd_pkg::StHdrErr;
			end else begin
				res.byte_stored = 1'b1;
				res.byte_index  = count_q;
				res.data_byte   = rx_byte;
				if (count_q != hlcd_pkg::PosHdr1) begin
					sum_d = '0;
				end
				count_d = cnt_next[hlcd_pkg::SizeW-1:0];
			end
		end else if (count_q < hlcd_pkg::PosFirst) begin
			// ID and LENGTH
			res.byte_stored = 1'b1;
			res.byte_index  = count_q;
			res.data_byte   = rx_byte;
			sum_d           = sum_add;
			if (count_q == hlcd_pkg::PosLength) begin
				exp_len_d = {1'b0, rx_byte} + hlcd_pkg::LenOverhead;
			end
			count_d = cnt_next[hlcd_pkg::SizeW-1:0];
		end else if (count_q == hlcd_pkg::PosFirst && len_bad) begin
			// size check fails on the byte after LENGTH
			count_d    = '0;
			exp_len_d  = '0;
			sum_d      = '0;
			res.status = hlcd_pkg::StLenErr;
		end else begin
			res.byte_stored = 1'b1;
			res.byte_index  = count_q;
			res.data_byte   = rx_byte;
			if (cnt_next < {1'b0, exp_len_q}) begin
				sum_d   = sum_add;
				count_d = cnt_next[hlcd_pkg::SizeW-1:0];
			end else begin
				// checksum byte
				if (~sum_q == rx_byte) begin
					res.status        = hlcd_pkg::StDone;
					res.packet_length = cnt_next[hlcd_pkg::SizeW-1:0];
				end else begin
					res.status = hlcd_pkg::StCsumErr;
				end
				count_d = '0;
				sum_d   = '0;
			end
		end
	end

	// Frame state advances on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			exp_len_q <= '0;
			sum_q     <= '0;
		end else if (accept) begin
			count_q   <= count_d;
			exp_len_q <= exp_len_d;
			sum_q     <= sum_d;
		end
	end

	assign result = res;

endmodule

[hdl/header_length_checksum_deframer_core.sv]
// ----------------------------------------------------------------------------
// header_length_checksum_deframer_core: packet deframer top level
// Frames 0xFF 0xFF ID LENGTH ... CHECKSUM packets from a byte stream and
// reports one status word per received byte.
//
//   channel  direction  handshake            payload
//   s_       in         s_tvalid/s_tready    s_tdata: rx_byte
//   m_       out        m_tvalid/m_tready    m_tdata, m_tuser: result word
//   cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte per cycle unless the output stalls; each result is registered.
// The output register frees up in the same cycle it is read, so a byte is
// taken whenever the output is empty or being drained.
// Reset clears the frame state and loads the default size limits.
// Config writes are always ready and take effect on the next byte.
// ----------------------------------------------------------------------------
module header_length_checksum_deframer_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  m_tdata,   // [8:0] packet_length,
	                                                // [17:9] byte_index,
	                                                // [25:18] data_byte, rest 0
	output logic [3:0]                   m_tuser,   // [2:0] status, [3] byte_stored
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hlcd_pkg::IndexW-1:0]  cfg_index,
	input  logic [hlcd_pkg::SizeW-1:0]   cfg_data
);

	hlcd_pkg::cfg_t    cfg;
	hlcd_pkg::result_t result;
	hlcd_pkg::result_t out_q;
	logic              m_tvalid_q;
	logic              accept;

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_tvalid_q || m_tready;
	assign accept    = s_tvalid && s_tready;

	hlcd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hlcd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (s_tdata),
		.cfg     (cfg),
		.result  (result)
	);

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, out_q.data_byte, out_q.byte_index, out_q.packet_length};
	assign m_tuser  = {out_q.byte_stored, out_q.status};

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for header_length_checksum_deframer_core
// Drives received bytes on the input stream and checks every status word
// against a cycle-free framing predictor. A short directed table runs first,
// then packet-shaped random traffic under several size-limit settings, with
// random backpressure on both sides except in the last two phases.
// ----------------------------------------------------------------------------
module tb_top;

	// Directed table row; want is used only where typed is set
	typedef struct packed {
		logic [hlcd_pkg::ByteW-1:0] rx;
		bit                         typed;
		hlcd_pkg::result_t          want;
	} dir_row_t;

	localparam int unsigned NumDir = 26;

	localparam dir_row_t DirRows [NumDir] = '{
		// stray byte, then header byte followed by a non-header byte
		'{8'h00, 1'b1, '{hlcd_pkg::StHdrErr, 9'd0, 1'b0, 9'd0, 8'h00}},
		'{8'hFF, 1'b1, '{hlcd_pkg::StIdle,   9'd0, 1'b1, 9'd0, 8'hFF}},
		'{8'h7E, 1'b1, '{hlcd_pkg::StHdrErr, 9'd0, 1'b0, 9'd0, 8'h00}},
		// good six-byte packet
		'{8'hFF, 1'b1, '{hlcd_pkg::StIdle,   9'd0, 1'b1, 9'd0, 8'hFF}},
		'{8'hFF, 1'b1, '{hlcd_pkg::StIdle,   9'd0, 1'b1, 9'd1, 8'hFF}},
		'{8'h01, 1'b1, '{hlcd_pkg::StIdle,   9'd0, 1'b1, 9'd2, 8'h01}},
		'{8'h02, 1'b1, '{hlcd_pkg::StIdle,   9'd0, 1'b1, 9'd3, 8'h02}},
		'{8'h55, 1'b1, '{hlcd_pkg::StIdle,   9'd0, 1'b1, 9'd4, 8'h55}},
		'{8'hA7, 1'b1, '{hlcd_pkg::StDone,   9'd6, 1'b1, 9'd5, 8'hA7}},
		// size 4 is below the reset minimum
		'{8'hFF, 1'b1, '{hlcd_pkg::StIdle,   9'd0, 1'b1, 9'd0, 8'hFF}},
		'{8'hFF, 1'b1, '{hlcd_pkg::StIdle,   9'd0, 1'b1, 9'd1, 8'hFF}},
		'{8'h00, 1'b1, '{hlcd_pkg::StIdle,   9'd0, 1'b1, 9'd2, 8'h00}},
		'{8'h00, 1'b1, '{hlcd_pkg::StIdle,   9'd0, 1'b1, 9'd3, 8'h00}},
		'{8'h33, 1'b1, '{hlcd_pkg::StLenErr, 9'd0, 1'b0, 9'd0, 8'h00}},
		// bad checksum, byte still echoed
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'h01, 1'b0, '0},
		'{8'h02, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b1, '{hlcd_pkg::StCsumErr, 9'd0, 1'b1, 9'd5, 8'h00}},
		// all-ones ID and payload, sum wraps to zero
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'h02, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b1, '{hlcd_pkg::StDone,   9'd6, 1'b1, 9'd5, 8'hFF}}
	};

	// Random phases: size limits and byte budget per phase
	localparam int unsigned NumPhase = 6;
	localparam logic [hlcd_pkg::SizeW-1:0] PhaseMin [NumPhase] =
		'{9'd4, 9'd6, 9'd200, 9'd0, 9'd5, 9'd6};
	localparam logic [hlcd_pkg::SizeW-1:0] PhaseMax [NumPhase] =
		'{9'd259, 9'd20, 9'd100, 9'd0, 9'd5, 9'd259};
	localparam int unsigned PhaseBudget [NumPhase] = '{220, 220, 90, 90, 220, 300};

	// Register index that maps to no register
	localparam logic [hlcd_pkg::IndexW-1:0] RegUnused = 8'd2;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [31:0]                   m_tdata;
	logic [3:0]                    m_tuser;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [hlcd_pkg::IndexW-1:0]   cfg_index = '0;
	logic [hlcd_pkg::SizeW-1:0]    cfg_data = '0;

	// Framing predictor state and size limits
	logic [hlcd_pkg::SizeW-1:0]    rcv_count = '0;
	logic [hlcd_pkg::SizeW-1:0]    exp_len = '0;
	logic [hlcd_pkg::ByteW-1:0]    csum_acc = '0;
	logic [hlcd_pkg::SizeW-1:0]    lim_min = hlcd_pkg::MinSizeReset;
	logic [hlcd_pkg::SizeW-1:0]    lim_max = hlcd_pkg::MaxSizeReset;

	hlcd_pkg::result_t             status_words_due [$];
	int unsigned                   bytes_taken = 0;
	int unsigned                   regs_taken = 0;
	int unsigned                   fail_cnt = 0;
	int unsigned                   src_idle = 25;
	int unsigned                   snk_idle = 80;
	bit                            use_typed = 1'b0;
	hlcd_pkg::result_t             typed_word = '0;

	header_length_checksum_deframer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Advance the framer by one received byte, return its status word
	function automatic hlcd_pkg::result_t frame_byte(input logic [hlcd_pkg::ByteW-1:0] b);
		hlcd_pkg::result_t          r;
		logic [hlcd_pkg::SizeW-1:0] nxt;
		r   = '0;
		nxt = rcv_count + 9'd1;
		if (rcv_count < hlcd_pkg::PosHdr2) begin
			if (b != hlcd_pkg::HdrByte) begin
				rcv_count = '0;
				csum_acc  = '0;
				r.status  = hlcd_pkg::StHdrErr;
			end else begin
				r.byte_stored = 1'b1;
				r.byte_index  = rcv_count;
				r.data_byte   = b;
				if (rcv_count == '0)
					csum_acc = '0;
				rcv_count = nxt;
			end
		end else if (rcv_count < hlcd_pkg::PosFirst) begin
			r.byte_stored = 1'b1;
			r.byte_index  = rcv_count;
			r.data_byte   = b;
			csum_acc      = csum_acc + b;
			if (rcv_count == hlcd_pkg::PosLength)
				exp_len = {1'b0, b} + hlcd_pkg::LenOverhead;
			rcv_count = nxt;
		end else if (rcv_count == hlcd_pkg::PosFirst &&
				(exp_len < lim_min || exp_len > lim_max)) begin
			// size check fails on the byte after LENGTH
			rcv_count = '0;
			exp_len   = '0;
			csum_acc  = '0;
			r.status  = hlcd_pkg::StLenErr;
		end else begin
			r.byte_stored = 1'b1;
			r.byte_index  = rcv_count;
			r.data_byte   = b;
			if (nxt < exp_len) begin
				csum_acc  = csum_acc + b;
				rcv_count = nxt;
			end else begin
				if (~csum_acc == b) begin
					r.status        = hlcd_pkg::StDone;
					r.packet_length = nxt;
				end else begin
					r.status = hlcd_pkg::StCsumErr;
				end
				rcv_count = '0;
				csum_acc  = '0;
			end
		end
		return r;
	endfunction

	function automatic void cmp_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_cnt++;
		end
	endfunction

	// Predict on byte acceptance, track register writes, check status words
	always @(posedge clk) begin
		hlcd_pkg::result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want = frame_byte(s_tdata);
				status_words_due.push_back(use_typed ? typed_word : want);
				bytes_taken++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hlcd_pkg::RegMinSize: lim_min = cfg_data;
					hlcd_pkg::RegMaxSize: lim_max = cfg_data;
					default: ;
				endcase
				regs_taken++;
			end
			if (m_tvalid && m_tready) begin
				if (status_words_due.size() == 0) begin
					$error("status word with nothing expected: tuser %h tdata %h", m_tuser,
						m_tdata);
					fail_cnt++;
				end else begin
					want = status_words_due.pop_front();
					cmp_field("status", want.status, m_tuser[2:0]);
					cmp_field("byte_stored", want.byte_stored, m_tuser[3]);
					cmp_field("packet_length", want.packet_length, m_tdata[8:0]);
					cmp_field("byte_index", want.byte_index, m_tdata[17:9]);
					cmp_field("data_byte", want.data_byte, m_tdata[25:18]);
				end
			end
		end
	end

	// Receiver backpressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_idle);
	end

	// Offer one byte after idle cycles drawn per cycle, and wait until it is taken
	task automatic push_byte(input logic [hlcd_pkg::ByteW-1:0] b);
		int unsigned seen;
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		seen = bytes_taken;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(negedge clk); while (bytes_taken == seen);
	endtask

	// Stop sending until every status word has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		while (status_words_due.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [hlcd_pkg::IndexW-1:0] idx,
			input logic [hlcd_pkg::SizeW-1:0] val);
		int unsigned seen;
		seen = regs_taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (regs_taken == seen);
	endtask

	// LENGTH byte: mostly short packets, now and then a long one
	function automatic logic [hlcd_pkg::ByteW-1:0] pick_len();
		if ($urandom_range(15) != 0)
			return 8'($urandom_range(0, 10));
		if ($urandom_range(3) == 0)
			return 8'hFF;
		return 8'($urandom_range(11, 254));
	endfunction

	// Send one packet; cut stops it after that many bytes when nonzero
	task automatic send_packet(input bit good_sum, input int unsigned cut);
		logic [hlcd_pkg::ByteW-1:0] id;
		logic [hlcd_pkg::ByteW-1:0] len;
		logic [hlcd_pkg::ByteW-1:0] b;
		logic [hlcd_pkg::ByteW-1:0] sum;
		int unsigned                size;
		int unsigned                sum_pos;
		int unsigned                total;
		// finish whatever frame is open so the header lands at position 0
		while (rcv_count != '0) push_byte(8'($urandom_range(255)));
		id      = 8'($urandom_range(255));
		len     = pick_len();
		size    = len + hlcd_pkg::LenOverhead;
		sum_pos = (size < 5) ? 4 : size - 1;
		total   = sum_pos + 1;
		if (size < lim_min || size > lim_max)
			total = 5;
		if (cut != 0 && cut < total)
			total = cut;
		sum = id + len;
		for (int unsigned k = 0; k < total; k++) begin
			case (k)
				0, 1: b = hlcd_pkg::HdrByte;
				2: b = id;
				3: b = len;
				default: begin
					if (k == sum_pos)
						b = good_sum ? ~sum : ~sum ^ 8'($urandom_range(1, 255));
					else
						b = 8'($urandom_range(255));
					sum = sum + b;
				end
			endcase
			push_byte(b);
		end
	endtask

	// Main sequence
	initial begin
		int unsigned start;
		int unsigned pick;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table under the reset limits
		for (int i = 0; i < NumDir; i++) begin
			use_typed  = DirRows[i].typed;
			typed_word = DirRows[i].want;
			push_byte(DirRows[i].rx);
		end
		use_typed = 1'b0;

		for (int p = 0; p < NumPhase; p++) begin
			// limits change only with the pipe empty
			drain();
			repeat (2) @(negedge clk);
			write_reg(hlcd_pkg::RegMinSize, PhaseMin[p]);
			write_reg(hlcd_pkg::RegMaxSize, PhaseMax[p]);
			if (p == 2) begin
				// unknown indexes must leave the limits alone
				write_reg(RegUnused, 9'h1FF);
				write_reg({hlcd_pkg::IndexW{1'b1}}, 9'h1FF);
			end
			cfg_valid <= 1'b0;
			src_idle = (p < 2) ? 25 : (p < 4) ? 80 : 0;
			snk_idle = (p < 2) ? 80 : (p < 4) ? 25 : 0;
			start = bytes_taken;
			while (bytes_taken - start < PhaseBudget[p]) begin
				pick = $urandom_range(99);
				if (pick < 2)
					drain();
				else if (pick < 77)
					send_packet($urandom_range(99) < 85, 0);
				else if (pick < 87)
					send_packet(1'b1, $urandom_range(1, 6));
				else
					repeat ($urandom_range(1, 4))
						push_byte(($urandom_range(3) == 0) ? hlcd_pkg::HdrByte :
							8'($urandom_range(255)));
			end
		end

		drain();
		repeat (4) @(negedge clk);
		if (fail_cnt == 0 && status_words_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

[sim.f]
hdl/hlcd_pkg.sv
hdl/hlcd_cfg.sv
hdl/hlcd_parse.sv
hdl/header_length_checksum_deframer_core.sv
test/tb_top.sv
